FILE: design/sysres_pkg.sv
// Package for the systematic resampler: sizes, constants and controller/datapath link types.
`timescale 1ns / 1ps

package sysres_pkg;

  // Largest particle set the block handles
  localparam int unsigned MaxParticles = 64;

  // Field and state widths
  localparam int unsigned IdxW    = $clog2(MaxParticles);   // particle index, slot number
  localparam int unsigned CountW  = $clog2(MaxParticles + 1); // particle count register
  localparam int unsigned WeightW = 17;                       // Q1.16 weight, below 2.0
  localparam int unsigned OffsetW = 16;                       // Q0.16 start offset
  localparam int unsigned CumW    = 23;                       // running weight sum
  localparam int unsigned ThrW    = CumW + CountW;            // N * cum_weight
  localparam int unsigned PosW    = CumW;                     // offset + m * 2^16

  // Particle count after reset
  localparam logic [CountW-1:0] CountReset = CountW'(MaxParticles);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the input transaction, update the running sum
    logic calc;    // form the threshold N * cum_weight
    logic emit;    // load the output register with the current slot
    logic finish;  // commit the end of this weight
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic more;  // the current slot is covered by this weight
    logic last;  // the current slot is the last one this weight covers
  } dp_status_t;

endpackage

FILE: design/sysres_in_if.sv
// Input channel interface: one normalized weight and the set's start offset per transaction.
`timescale 1ns / 1ps

interface sysres_in_if;
  logic                               valid;
  logic                               ready;
  logic [sysres_pkg::WeightW-1:0]     weight;
  logic [sysres_pkg::OffsetW-1:0]     offset;

  modport source (output valid, output weight, output offset, input ready);
  modport sink   (input valid, input weight, input offset, output ready);
endinterface

FILE: design/sysres_out_if.sv
// Output channel interface: one resampled slot assignment per transaction.
`timescale 1ns / 1ps

interface sysres_out_if;
  logic                            valid;
  logic                            ready;
  logic [sysres_pkg::IdxW-1:0]     ancestor;
  logic [sysres_pkg::IdxW-1:0]     slot;
  logic                            run_last;
  logic                            set_done;

  modport source (output valid, output ancestor, output slot, output run_last,
                  output set_done, input ready);
  modport sink   (input valid, input ancestor, input slot, input run_last,
                  input set_done, output ready);
endinterface

FILE: design/sysres_datapath.sv
// Datapath of the systematic resampler: running sum, threshold, slot compare, output register.
`timescale 1ns / 1ps

module sysres_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sysres_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic [sysres_pkg::WeightW-1:0]  weight_i,
  input  logic [sysres_pkg::OffsetW-1:0]  offset_i,
  input  sysres_pkg::ctrl_cmd_t           cmd_i,
  output sysres_pkg::dp_status_t          status_o,
  output logic [sysres_pkg::IdxW-1:0]     ancestor_o,
  output logic [sysres_pkg::IdxW-1:0]     slot_o,
  output logic                            run_last_o,
  output logic                            set_done_o
);

  localparam int unsigned IdxW   = sysres_pkg::IdxW;
  localparam int unsigned CountW = sysres_pkg::CountW;
  localparam int unsigned CumW   = sysres_pkg::CumW;
  localparam int unsigned ThrW   = sysres_pkg::ThrW;
  localparam int unsigned PosW   = sysres_pkg::PosW;
  localparam int unsigned OffW   = sysres_pkg::OffsetW;

  logic [CountW-1:0] count_q;
  logic [CumW-1:0]   cum_q, cum_d;
  logic [IdxW-1:0]   seen_q, seen_d;
  logic [CountW-1:0] slot_q, slot_d;
  logic [OffW-1:0]   offset_q, offset_d;
  logic              closing_q, closing_d;
  logic [ThrW-1:0]   thr_q;

  logic [CountW-1:0] n_eff;
  logic [CumW:0]     cum_sum;
  logic [CumW-1:0]   cum_sat;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   pos_next;
  logic [CountW-1:0] slot_inc;

  // Effective particle count: zero acts as one, the top is clamped
  always_comb begin
    n_eff = count_q;
    if (count_q == '0) begin
      n_eff = CountW'(1);
    end else if (count_q > sysres_pkg::CountReset) begin
      n_eff = sysres_pkg::CountReset;
    end
  end

  // Saturating running sum
  assign cum_sum = {1'b0, cum_q} + (CumW + 1)'(weight_i);
  assign cum_sat = cum_sum[CumW] ? {CumW{1'b1}} : cum_sum[CumW-1:0];

  // Sample position of the current slot and of the one after it
  assign pos      = PosW'(offset_q) + (PosW'(slot_q[IdxW-1:0]) << 16);
  assign pos_next = pos + PosW'(32'h1_0000);
  assign slot_inc = slot_q + CountW'(1);

  always_comb begin
    status_o.more = (slot_q < n_eff) && (closing_q || (ThrW'(pos) <= thr_q));
    status_o.last = (slot_inc == n_eff) || (!closing_q && (ThrW'(pos_next) > thr_q));
  end

  // Set state next values
  always_comb begin
    cum_d     = cum_q;
    seen_d    = seen_q;
    slot_d    = slot_q;
    offset_d  = offset_q;
    closing_d = closing_q;
    if (cmd_i.accept) begin
      cum_d     = cum_sat;
      closing_d = ({1'b0, seen_q} + CountW'(1)) >= n_eff;
      if (seen_q == '0) begin
        offset_d = offset_i;
      end
    end
    if (cmd_i.emit) begin
      slot_d = slot_inc;
    end
    if (cmd_i.finish) begin
      if (closing_q) begin
        cum_d    = '0;
        seen_d   = '0;
        slot_d   = '0;
        offset_d = '0;
      end else begin
        seen_d = seen_q + IdxW'(1);
      end
    end
    // A register write starts a new set
    if (cfg_we_i) begin
      cum_d    = '0;
      seen_d   = '0;
      slot_d   = '0;
      offset_d = '0;
    end
  end

  // Set state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= sysres_pkg::CountReset;
      cum_q     <= '0;
      seen_q    <= '0;
      slot_q    <= '0;
      offset_q  <= '0;
      closing_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      cum_q     <= cum_d;
      seen_q    <= seen_d;
      slot_q    <= slot_d;
      offset_q  <= offset_d;
      closing_q <= closing_d;
    end
  end

  // Threshold product and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      thr_q <= ThrW'(n_eff) * ThrW'(cum_q);
    end
    if (cmd_i.emit) begin
      ancestor_o <= seen_q;
      slot_o     <= slot_q[IdxW-1:0];
      run_last_o <= status_o.last;
      set_done_o <= (slot_inc == n_eff);
    end
  end

endmodule

FILE: design/sysres_ctrl.sv
// Controller of the systematic resampler: sequences accept, threshold and slot emission.
`timescale 1ns / 1ps

module sysres_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  sysres_pkg::dp_status_t  status_i,
  output sysres_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (!status_i.more) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/systematic_resampler.sv
// Top level of the systematic resampler: channels, configuration port, controller and datapath.
// Systematic resampling for a particle filter. Send N normalized Q1.16 weights per set (N is
// particle_count, written through cfg_we_i/cfg_wdata_i while idle; a write starts a new set).
// The offset field is taken from the first weight of each set. Each weight produces the slot
// assignments it covers, one result transaction per cycle while the output register can take
// it, and the last weight of a set flushes every open slot, so a set always yields exactly N
// results. A weight is handled in steps: accept and add, the N * sum multiply, then one
// emitted slot per step (or a single step when it covers none). Results pass through an
// output register, so the final result of a weight may wait while the next weight is
// accepted.
`timescale 1ns / 1ps

module systematic_resampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sysres_pkg::CountW-1:0]  cfg_wdata_i,
  sysres_in_if.sink                      in_ch_i,
  sysres_out_if.source                   out_ch_o
);

  sysres_pkg::ctrl_cmd_t  cmd;
  sysres_pkg::dp_status_t status;

  // Control sequencer
  sysres_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and set state
  sysres_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .weight_i    (in_ch_i.weight),
    .offset_i    (in_ch_i.offset),
    .cmd_i       (cmd),
    .status_o    (status),
    .ancestor_o  (out_ch_o.ancestor),
    .slot_o      (out_ch_o.slot),
    .run_last_o  (out_ch_o.run_last),
    .set_done_o  (out_ch_o.set_done)
  );

endmodule

FILE: tb/systematic_resampler_tb.sv
// Testbench for the systematic resampler: directed and random weight sets checked slot by slot.
`timescale 1ns / 1ps

module systematic_resampler_tb;

  localparam int unsigned MaxParticles = sysres_pkg::MaxParticles;
  localparam int unsigned IdxW         = sysres_pkg::IdxW;
  localparam int unsigned CountW       = sysres_pkg::CountW;
  localparam int unsigned WeightW      = sysres_pkg::WeightW;
  localparam int unsigned OffsetW      = sysres_pkg::OffsetW;
  localparam int unsigned CumW         = sysres_pkg::CumW;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned MaxGap       = 24;
  localparam int unsigned OneQ16       = 65536;
  localparam int unsigned WeightMax    = (1 << WeightW) - 1;
  localparam int unsigned OffsetMax    = (1 << OffsetW) - 1;
  localparam int unsigned SumMax       = (1 << CumW) - 1;
  localparam int unsigned CountMax     = (1 << CountW) - 1;

  // One expected slot assignment
  typedef struct packed {
    logic [IdxW-1:0] ancestor;
    logic [IdxW-1:0] slot;
    logic            run_last;
    logic            set_done;
  } slot_pick_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  sysres_in_if  in_if ();
  sysres_out_if out_if ();

  systematic_resampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch_i     (in_if),
    .out_ch_o    (out_if)
  );

  // Resampler state as the testbench tracks it
  logic [CountW-1:0] count_reg = sysres_pkg::CountReset;
  int unsigned       run_sum;
  int unsigned       weights_in_set;
  int unsigned       open_slot;
  int unsigned       set_offset;

  slot_pick_t  expected_picks[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;

  always #1 clk_i = ~clk_i;

  // Particle count as the block uses it
  function automatic int unsigned eff_count(input logic [CountW-1:0] c);
    int unsigned n;
    n = c;
    if (n == 0) n = 1;
    if (n > MaxParticles) n = MaxParticles;
    return n;
  endfunction

  // Scaled position of slot m: offset + m * 2^16
  function automatic longint unsigned slot_pos(input int unsigned m);
    return longint'(set_offset) + (longint'(m) << 16);
  endfunction

  function automatic void clear_set();
    run_sum        = 0;
    weights_in_set = 0;
    open_slot      = 0;
    set_offset     = 0;
  endfunction

  // Work out the slot assignments caused by one accepted weight
  task automatic predict_picks(input logic [WeightW-1:0] w, input logic [OffsetW-1:0] off);
    int unsigned       n;
    int unsigned       m;
    longint unsigned   thr;
    bit                closing;
    slot_pick_t        pick;
    n = eff_count(count_reg);
    if (weights_in_set == 0) set_offset = off;
    run_sum = run_sum + w;
    if (run_sum > SumMax) run_sum = SumMax;
    closing = (weights_in_set + 1 >= n);
    thr = longint'(n) * longint'(run_sum);
    m = open_slot;
    // closing weight flushes every open slot to the last index
    while (m < n && (closing || slot_pos(m) <= thr)) begin
      pick.ancestor = IdxW'(weights_in_set);
      pick.slot     = IdxW'(m);
      pick.set_done = (m + 1 == n);
      pick.run_last = (m + 1 >= n) || (!closing && slot_pos(m + 1) > thr);
      expected_picks = {expected_picks, pick};
      m++;
    end
    if (closing) begin
      clear_set();
    end else begin
      open_slot      = m;
      weights_in_set = (weights_in_set + 1) & (MaxParticles - 1);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Wait until every expected result is in and the block has gone quiet
  task automatic settle();
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the particle count while idle; the write also restarts the set
  task automatic write_particle_count(input int unsigned value);
    in_if.valid <= 1'b0;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(posedge clk_i);
    count_reg = CountW'(value);
    clear_set();
    cfg_we_i <= 1'b0;
  endtask

  // Send one weight transaction, with a random gap ahead of it
  task automatic send_weight(input int unsigned w, input int unsigned off);
    int unsigned idle;
    idle = 0;
    while (idle < MaxGap && $urandom_range(99) < gap_pct) idle++;
    if (idle > 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.weight <= WeightW'(w);
    in_if.offset <= OffsetW'(off);
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_picks(WeightW'(w), OffsetW'(off));
    items_sent++;
  endtask

  // Send the first count weights of a set of n that sums to one
  task automatic send_normalized(input int unsigned n, input int unsigned count);
    int unsigned     raw[MaxParticles];
    longint unsigned total;
    longint unsigned acc;
    int unsigned     w;
    total = 0;
    acc   = 0;
    for (int i = 0; i < n; i++) begin
      raw[i] = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 1000);
      total += raw[i];
    end
    if (total == 0) begin
      raw[0] = 1;
      total  = 1;
    end
    for (int i = 0; i < count; i++) begin
      if (i == n - 1) w = 32'(OneQ16 - acc);
      else w = 32'((longint'(raw[i]) * OneQ16) / total);
      acc += w;
      send_weight(w, $urandom_range(0, OffsetMax));
    end
  endtask

  // Unnormalized weights, including ones above 1.0
  task automatic send_noise(input int unsigned count);
    int unsigned w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1) == 0) w = $urandom_range(0, WeightMax);
      else w = $urandom_range(0, (2 * OneQ16) / count);
      send_weight(w, $urandom_range(0, OffsetMax));
    end
  endtask

  // Reset count of 64: a full weight covers every slot, later weights cover none
  task automatic test_reset_count();
    send_weight(OneQ16, OffsetMax);
    send_weight(0, 0);
    send_weight(WeightMax, OffsetMax);
  endtask

  // Count of 0 acts as 1, counts above the maximum act as the maximum
  task automatic test_count_limits();
    write_particle_count(0);
    send_weight(0, 0);
    send_weight(WeightMax, OffsetMax);
    write_particle_count(CountMax);
    send_weight(OneQ16, 0);
    write_particle_count(1);
    send_weight(1, 12345);
  endtask

  // Equality keeps the index, zero weights, sums not reaching one, weights above one
  task automatic test_slot_boundaries();
    write_particle_count(4);
    repeat (4) send_weight(OneQ16 / 4, 0);
    write_particle_count(3);
    repeat (3) send_weight(0, OffsetMax);
    write_particle_count(2);
    repeat (2) send_weight(WeightMax, 0);
    write_particle_count(MaxParticles);
    send_weight(OneQ16 / 2, OffsetMax);
  endtask

  // Random sets: mostly well formed, some cut short, some unnormalized
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned items);
    int unsigned goal;
    int unsigned r;
    int unsigned n;
    int unsigned len;
    gap_pct   = gap;
    stall_pct = stall;
    goal      = items_sent + items;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 55) write_particle_count($urandom_range(1, 8));
      else if (r < 63) write_particle_count($urandom_range(9, MaxParticles - 1));
      else if (r < 67) write_particle_count(MaxParticles);
      else if (r < 72) write_particle_count(0);
      else if (r < 76) write_particle_count($urandom_range(MaxParticles + 1, CountMax));
      n = eff_count(count_reg);
      // keep the phase close to its item budget
      len = n;
      if (len > goal - items_sent) len = goal - items_sent;
      r = $urandom_range(99);
      if (r < 75) send_normalized(n, len);
      else if (r < 88) send_normalized(n, $urandom_range(1, len));
      else send_noise(len);
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_picks
    slot_pick_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result: ancestor %0d slot %0d",
                                  out_if.ancestor, out_if.slot));
      end else begin
        want = expected_picks.pop_front();
        if (out_if.ancestor !== want.ancestor)
          report_mismatch($sformatf("slot %0d ancestor: got %0d, expected %0d",
                                    want.slot, out_if.ancestor, want.ancestor));
        if (out_if.slot !== want.slot)
          report_mismatch($sformatf("slot: got %0d, expected %0d", out_if.slot, want.slot));
        if (out_if.run_last !== want.run_last)
          report_mismatch($sformatf("slot %0d run_last: got %0b, expected %0b",
                                    want.slot, out_if.run_last, want.run_last));
        if (out_if.set_done !== want.set_done)
          report_mismatch($sformatf("slot %0d set_done: got %0b, expected %0b",
                                    want.slot, out_if.set_done, want.set_done));
      end
    end
  end

  // Cycle counter for a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("systematic_resampler test failed");
    $finish;
  end

  // Test sequence
  initial begin
    in_if.valid  <= 1'b0;
    in_if.weight <= '0;
    in_if.offset <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    errors       = 0;
    items_sent   = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    clear_set();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count();
    test_count_limits();
    test_slot_boundaries();
    test_random_traffic(0, 0, 50);
    test_random_traffic(51, 0, 50);
    test_random_traffic(0, 51, 50);
    test_random_traffic(16, 16, 50);

    // drain
    in_if.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("systematic_resampler test passed");
    end else begin
      $display("systematic_resampler test failed");
    end
    $finish;
  end

endmodule
